// ===== sv/rgb_gaussian_blur_3x3_core_assert.svh =====
// assertion macros for the gaussian blur core
// used by the queue, front and back modules; needs nothing else
`ifndef RGB_GAUSSIAN_BLUR_3X3_CORE_ASSERT_SVH
`define RGB_GAUSSIAN_BLUR_3X3_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RGBGB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgbgb assertion failed");

// next-cycle implication, checked out of reset
`define RGBGB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgbgb assertion failed");

`endif

// ===== sv/rgbgb_pkg.sv =====
// types, constants and tap functions shared by the gaussian blur core
// no dependencies
`default_nettype none

package rgbgb_pkg;

    localparam int CFG_W       = 12;
    localparam int CFG_INDEX_W = 1;
    localparam int HEIGHT_W    = 12;
    localparam int TAP_W       = 15;
    localparam int SUM_W       = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd1920;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd1080;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam int CH_RED   = 2;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 0;

    localparam logic [TAP_W-1:0] W_CORNER = 15'd19;
    localparam logic [TAP_W-1:0] W_EDGE   = 15'd32;
    localparam logic [TAP_W-1:0] W_CENTRE = 15'd52;

    typedef logic [2:0][7:0] pix_t;

    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } col_t;

    typedef struct packed {
        pix_t upper;
        pix_t middle;
    } line_word_t;

    typedef struct packed {
        col_t left;
        col_t centre;
        col_t right;
        logic emit_a;
        logic emit_b;
        logic eof;
    } q_entry_t;

    // weighted vertical sum of an outer column
    function automatic logic [TAP_W-1:0] side_tap(input logic [7:0] t, input logic [7:0] m,
                                                  input logic [7:0] b);
        logic [TAP_W-1:0] tb;
        tb = TAP_W'(t) + TAP_W'(b);
        return (tb * W_CORNER) + (TAP_W'(m) * W_EDGE);
    endfunction

    // weighted vertical sum of the centre column
    function automatic logic [TAP_W-1:0] centre_tap(input logic [7:0] t, input logic [7:0] m,
                                                    input logic [7:0] b);
        logic [TAP_W-1:0] tb;
        tb = TAP_W'(t) + TAP_W'(b);
        return (tb * W_EDGE) + (TAP_W'(m) * W_CENTRE);
    endfunction

endpackage

`default_nettype wire

// ===== sv/rgbgb_queue.sv =====
// short queue of window entries between the front and back parts
// depends on rgbgb_pkg and the assertion macro header
`default_nettype none
`include "rgb_gaussian_blur_3x3_core_assert.svh"

module rgbgb_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rgbgb_pkg::q_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output rgbgb_pkg::q_entry_t head,
    output logic                not_empty
);

    localparam int DEPTH = rgbgb_pkg::QUEUE_DEPTH;
    localparam int PW    = rgbgb_pkg::QPTR_W;

    rgbgb_pkg::q_entry_t slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;

    assign full      = (count_reg == (PW+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `RGBGB_ASSERT_IMPL(a_q_no_overflow, clk, rst_n, push, !full)
    `RGBGB_ASSERT_IMPL(a_q_no_underflow, clk, rst_n, pop, not_empty)
    `RGBGB_ASSERT_IMPL(a_q_count_bound, clk, rst_n, 1'b1, count_reg <= (PW+1)'(DEPTH))

endmodule

`default_nettype wire

// ===== sv/rgbgb_front.sv =====
// front part: config registers, item classification, frame counters,
// line store and 3x3 window; depends on rgbgb_pkg and the assertion header
`default_nettype none
`include "rgb_gaussian_blur_3x3_core_assert.svh"

module rgbgb_front #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_en,
    input  logic [rgbgb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rgbgb_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  op,
    input  logic [7:0]                            in_red,
    input  logic [7:0]                            in_green,
    input  logic [7:0]                            in_blue,
    output logic                                  q_push,
    output rgbgb_pkg::q_entry_t                   q_entry,
    input  logic                                  q_full
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = AW + 1;
    localparam int CW = (WW > rgbgb_pkg::CFG_W) ? WW : rgbgb_pkg::CFG_W;
    localparam int HW = rgbgb_pkg::HEIGHT_W;

    logic [rgbgb_pkg::CFG_W-1:0] frame_width_reg;
    logic [rgbgb_pkg::CFG_W-1:0] frame_height_reg;
    logic [CW-1:0]               fw_ext;
    logic [WW-1:0]               eff_w;
    logic [HW-1:0]               eff_h;

    logic [AW-1:0] col_reg, col_next;
    logic [AW-1:0] drain_reg, drain_next;
    logic [HW-1:0] row_reg, row_next;

    logic          is_pix, is_drn, take, load;
    logic [AW-1:0] cur;
    logic          cur_last, may_emit;
    rgbgb_pkg::pix_t in_pix;

    logic                   s1_valid_reg;
    logic                   s1_drain_reg;
    logic [AW-1:0]          s1_addr_reg;
    rgbgb_pkg::pix_t        s1_pix_reg;
    logic                   s1_restart_reg;
    logic                   s1_top_mid_reg;
    logic                   s1_emit_a_reg;
    logic                   s1_emit_b_reg;
    logic                   s1_fwd_reg;
    rgbgb_pkg::line_word_t  s1_fwd_word_reg;
    rgbgb_pkg::line_word_t  line_rdata_reg;
    rgbgb_pkg::line_word_t  line_mem [MAX_WIDTH];

    rgbgb_pkg::line_word_t  s1_word;
    rgbgb_pkg::col_t        new_col;
    logic                   s1_emit_any, s1_go, s1_open, s1_write;

    rgbgb_pkg::col_t win_left_reg, win_left_next;
    rgbgb_pkg::col_t win_centre_reg, win_centre_next;
    rgbgb_pkg::col_t win_right_reg, win_right_next;

    // register bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= rgbgb_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= rgbgb_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                rgbgb_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                rgbgb_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
            endcase
        end
    end

    assign fw_ext = CW'(frame_width_reg);

    always_comb
    begin
        priority if (fw_ext == '0)
            eff_w = WW'(1);
        else if (fw_ext > CW'(MAX_WIDTH))
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(fw_ext);
    end

    assign eff_h = (frame_height_reg == '0) ? HW'(1) : HW'(frame_height_reg);

    // classification
    assign in_pix   = {in_red, in_green, in_blue};
    assign is_pix   = (op == rgbgb_pkg::OP_PIXEL) && (row_reg < eff_h);
    assign is_drn   = (op == rgbgb_pkg::OP_DRAIN) && (row_reg >= eff_h);
    assign cur      = is_drn ? drain_reg : col_reg;
    assign cur_last = (WW'(cur) + WW'(1)) >= eff_w;
    assign may_emit = is_drn || (row_reg != '0);
    assign take     = in_valid && !in_stall;
    assign load     = take && (is_pix || is_drn);

    always_comb
    begin
        col_next   = col_reg;
        drain_next = drain_reg;
        row_next   = row_reg;
        if (take && is_pix)
        begin
            if (cur_last)
            begin
                col_next = '0;
                row_next = row_reg + HW'(1);
            end
            else
            begin
                col_next = col_reg + AW'(1);
            end
        end
        else if (take && is_drn)
        begin
            if (cur_last)
            begin
                drain_next = '0;
                col_next   = '0;
                row_next   = '0;
            end
            else
            begin
                drain_next = drain_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            drain_reg <= '0;
            row_reg   <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            drain_reg <= drain_next;
            row_reg   <= row_next;
        end
    end

    // second stage: line data ready, window shifts, entry goes to the queue
    assign s1_word     = s1_fwd_reg ? s1_fwd_word_reg : line_rdata_reg;
    assign s1_emit_any = s1_emit_a_reg || s1_emit_b_reg;
    assign s1_go       = !(s1_emit_any && q_full);
    assign s1_open     = !s1_valid_reg || s1_go;
    assign in_stall    = !s1_open;
    assign s1_write    = s1_valid_reg && s1_go && !s1_drain_reg;

    always_comb
    begin
        new_col.mid = s1_word.middle;
        new_col.top = s1_top_mid_reg ? s1_word.middle : s1_word.upper;
        new_col.bot = s1_drain_reg ? s1_word.middle : s1_pix_reg;
        if (s1_restart_reg)
        begin
            win_left_next   = new_col;
            win_centre_next = new_col;
            win_right_next  = new_col;
        end
        else
        begin
            win_left_next   = win_centre_reg;
            win_centre_next = win_right_reg;
            win_right_next  = new_col;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            win_left_reg   <= '0;
            win_centre_reg <= '0;
            win_right_reg  <= '0;
        end
        else
        begin
            if (s1_open)
            begin
                s1_valid_reg <= load;
            end
            if (s1_valid_reg && s1_go)
            begin
                win_left_reg   <= win_left_next;
                win_centre_reg <= win_centre_next;
                win_right_reg  <= win_right_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_open && load)
        begin
            s1_drain_reg    <= is_drn;
            s1_addr_reg     <= cur;
            s1_pix_reg      <= in_pix;
            s1_restart_reg  <= (cur == '0);
            s1_top_mid_reg  <= is_drn ? (eff_h == HW'(1)) : (row_reg <= HW'(1));
            s1_emit_a_reg   <= may_emit && (cur != '0);
            s1_emit_b_reg   <= may_emit && cur_last;
            // same-address write still in flight from the item ahead
            s1_fwd_reg      <= s1_write && (s1_addr_reg == cur);
            s1_fwd_word_reg <= '{upper: s1_word.middle, middle: s1_pix_reg};
        end
    end

    // line store, read-first
    always_ff @(posedge clk)
    begin
        if (s1_open && load)
        begin
            line_rdata_reg <= line_mem[cur];
        end
        if (s1_write)
        begin
            line_mem[s1_addr_reg] <= '{upper: s1_word.middle, middle: s1_pix_reg};
        end
    end

    assign q_push         = s1_valid_reg && s1_go && s1_emit_any;
    assign q_entry.left   = win_left_next;
    assign q_entry.centre = win_centre_next;
    assign q_entry.right  = win_right_next;
    assign q_entry.emit_a = s1_emit_a_reg;
    assign q_entry.emit_b = s1_emit_b_reg;
    assign q_entry.eof    = s1_drain_reg;

    `RGBGB_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_reg && !s1_go,
                       s1_valid_reg && $stable(s1_addr_reg))
    `RGBGB_ASSERT_IMPL(a_stall_cause, clk, rst_n, in_stall,
                       s1_valid_reg && s1_emit_any && q_full)

endmodule

`default_nettype wire

// ===== sv/rgbgb_back.sv =====
// back part: picks one or two results per queue entry, column taps,
// horizontal sum and output register; depends on rgbgb_pkg and the assertion header
`default_nettype none
`include "rgb_gaussian_blur_3x3_core_assert.svh"

module rgbgb_back (
    input  logic                clk,
    input  logic                rst_n,
    input  rgbgb_pkg::q_entry_t q_head,
    input  logic                q_valid,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          out_red,
    output logic [7:0]          out_green,
    output logic [7:0]          out_blue,
    output logic                end_of_frame,
    output logic                run_last
);

    localparam int TW = rgbgb_pkg::TAP_W;
    localparam int SW = rgbgb_pkg::SUM_W;

    logic            phase_reg, phase_next;
    logic            take_a, sel_last, sel_eof, issue;
    rgbgb_pkg::col_t sel_l, sel_c, sel_r;

    logic          p1_valid_reg;
    logic          p1_eof_reg;
    logic          p1_last_reg;
    logic [TW-1:0] p1_l_reg [3];
    logic [TW-1:0] p1_c_reg [3];
    logic [TW-1:0] p1_r_reg [3];
    logic          p1_ready;

    logic            out_valid_reg;
    logic            out_eof_reg;
    logic            out_last_reg;
    rgbgb_pkg::pix_t out_pix_reg, out_pix_next;
    logic            out_free;

    // result select: full window first, then the right-edge copy
    assign take_a   = q_head.emit_a && !phase_reg;
    assign sel_last = !(take_a && q_head.emit_b);
    assign sel_eof  = take_a ? 1'b0 : q_head.eof;
    assign sel_l    = take_a ? q_head.left : q_head.centre;
    assign sel_c    = take_a ? q_head.centre : q_head.right;
    assign sel_r    = q_head.right;

    assign out_free   = !out_valid_reg || !out_stall;
    assign p1_ready   = !p1_valid_reg || out_free;
    assign issue      = q_valid && p1_ready;
    assign q_pop      = issue && sel_last;
    assign phase_next = issue ? !sel_last : phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (p1_ready)
            begin
                p1_valid_reg <= issue;
            end
            if (out_free)
            begin
                out_valid_reg <= p1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            p1_eof_reg  <= sel_eof;
            p1_last_reg <= sel_last;
            for (int ch = 0; ch < 3; ch++)
            begin
                p1_l_reg[ch] <= rgbgb_pkg::side_tap(sel_l.top[ch], sel_l.mid[ch], sel_l.bot[ch]);
                p1_c_reg[ch] <= rgbgb_pkg::centre_tap(sel_c.top[ch], sel_c.mid[ch],
                                                      sel_c.bot[ch]);
                p1_r_reg[ch] <= rgbgb_pkg::side_tap(sel_r.top[ch], sel_r.mid[ch], sel_r.bot[ch]);
            end
        end
    end

    // weights add up to 256, so the top byte of the sum never overflows
    always_comb
    begin
        logic [SW-1:0] sum;
        for (int ch = 0; ch < 3; ch++)
        begin
            sum = SW'(p1_l_reg[ch]) + SW'(p1_c_reg[ch]) + SW'(p1_r_reg[ch]);
            out_pix_next[ch] = sum[SW-1:SW-8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && p1_valid_reg)
        begin
            out_pix_reg  <= out_pix_next;
            out_eof_reg  <= p1_eof_reg;
            out_last_reg <= p1_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_red      = out_pix_reg[rgbgb_pkg::CH_RED];
    assign out_green    = out_pix_reg[rgbgb_pkg::CH_GREEN];
    assign out_blue     = out_pix_reg[rgbgb_pkg::CH_BLUE];
    assign end_of_frame = out_eof_reg;
    assign run_last     = out_last_reg;

    `RGBGB_ASSERT_IMPL(a_phase_pending, clk, rst_n, phase_reg,
                       q_valid && q_head.emit_a && q_head.emit_b)

endmodule

`default_nettype wire

// ===== sv/rgb_gaussian_blur_3x3_core.sv =====
// path: an accepted item passes the s1, queue, tap and output registers; a second result of
// an item follows the first; in item terms output trails input by one row and one pixel
// throughput: one item per cycle while in_stall is low, output one result per cycle while
// out_stall is low; the single blur datapath holds a two-result row-ending item at the queue head
// reset: counters, window, config, valid flags reset at once; data regs, line store not cleared
// top level of the gaussian blur core; depends on rgbgb_pkg, rgbgb_front, rgbgb_queue, rgbgb_back
`default_nettype none

module rgb_gaussian_blur_3x3_core #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [rgbgb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rgbgb_pkg::CFG_W-1:0]       cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              op,
    input  logic [7:0]                        in_red,
    input  logic [7:0]                        in_green,
    input  logic [7:0]                        in_blue,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        out_red,
    output logic [7:0]                        out_green,
    output logic [7:0]                        out_blue,
    output logic                              end_of_frame,
    output logic                              run_last
);

    logic                q_push;
    logic                q_full;
    logic                q_pop;
    logic                q_not_empty;
    rgbgb_pkg::q_entry_t q_push_entry;
    rgbgb_pkg::q_entry_t q_head;

    rgbgb_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .in_red       (in_red),
        .in_green     (in_green),
        .in_blue      (in_blue),
        .q_push       (q_push),
        .q_entry      (q_push_entry),
        .q_full       (q_full)
    );

    rgbgb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .not_empty  (q_not_empty)
    );

    rgbgb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_head       (q_head),
        .q_valid      (q_not_empty),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .end_of_frame (end_of_frame),
        .run_last     (run_last)
    );

endmodule

`default_nettype wire

// ===== verif/rgb_gaussian_blur_3x3_core_tb.sv =====
// self-checking testbench for rgb_gaussian_blur_3x3_core: streams frames through the blur,
// predicts every blurred pixel in a behavioural line-buffer model and compares on the fly
// depends on rgbgb_pkg and rgb_gaussian_blur_3x3_core
`default_nettype none

module rgb_gaussian_blur_3x3_core_tb;

    localparam int          LINE_DEPTH    = 2048;
    localparam int          CORNER_WEIGHT = 19;
    localparam int          SIDE_WEIGHT   = 32;
    localparam int          CENTRE_WEIGHT = 52;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          RANDOM_ITEMS  = 850;
    localparam int          HOLD_CYCLES   = 400;
    localparam int unsigned CYCLE_LIMIT   = 4000000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       eof;
        logic       last;
    } blur_result_t;

    logic                              clk          = 1'b0;
    logic                              rst_n        = 1'b0;
    logic                              cfg_write_en = 1'b0;
    logic [rgbgb_pkg::CFG_INDEX_W-1:0] cfg_index    = rgbgb_pkg::REG_FRAME_WIDTH;
    logic [rgbgb_pkg::CFG_W-1:0]       cfg_data     = '0;
    logic                              in_valid     = 1'b0;
    logic                              in_stall;
    logic                              op           = rgbgb_pkg::OP_PIXEL;
    logic [7:0]                        in_red       = '0;
    logic [7:0]                        in_green     = '0;
    logic [7:0]                        in_blue      = '0;
    logic                              out_valid;
    logic                              out_stall    = 1'b0;
    logic [7:0]                        out_red;
    logic [7:0]                        out_green;
    logic [7:0]                        out_blue;
    logic                              end_of_frame;
    logic                              run_last;

    // blur model state
    rgbgb_pkg::pix_t             upper_store [LINE_DEPTH];
    rgbgb_pkg::pix_t             middle_store[LINE_DEPTH];
    rgbgb_pkg::pix_t             win_cols[3][3];
    int unsigned                 col_cnt   = 0;
    int unsigned                 row_cnt   = 0;
    int unsigned                 drain_cnt = 0;
    logic [rgbgb_pkg::CFG_W-1:0] width_reg  = rgbgb_pkg::FRAME_WIDTH_RST;
    logic [rgbgb_pkg::CFG_W-1:0] height_reg = rgbgb_pkg::FRAME_HEIGHT_RST;

    blur_result_t expected_q[$];
    int           error_count   = 0;
    int unsigned  counted_items = 0;
    int unsigned  cycle_count   = 0;
    logic         send_idle     = 1'b1;
    logic         recv_idle     = 1'b1;
    int           hold_requests = 0;

    rgb_gaussian_blur_3x3_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .in_red       (in_red),
        .in_green     (in_green),
        .in_blue      (in_blue),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .end_of_frame (end_of_frame),
        .run_last     (run_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned active_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > LINE_DEPTH)
            return LINE_DEPTH;
        return 32'(width_reg);
    endfunction

    function automatic int unsigned active_height();
        return (height_reg == 0) ? 1 : 32'(height_reg);
    endfunction

    function automatic int unsigned idle_gap(input logic enabled);
        if (!enabled)
            return 0;
        return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 14) : 0;
    endfunction

    function automatic logic [7:0] random_channel();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // right_col repeats the newest column, as at the right border
    function automatic blur_result_t blur_pixels(input logic right_col, input logic eof);
        blur_result_t res;
        int unsigned  acc;
        int           ch;
        int           c;
        int           r;
        int           src;
        int           weight;
        logic [7:0]   chan[3];
        for (ch = 0; ch < 3; ch++)
        begin
            acc = 0;
            for (c = 0; c < 3; c++)
            begin
                src = right_col ? ((c == 0) ? 1 : 2) : c;
                for (r = 0; r < 3; r++)
                begin
                    if (r == 1 && c == 1)
                        weight = CENTRE_WEIGHT;
                    else if (r == 1 || c == 1)
                        weight = SIDE_WEIGHT;
                    else
                        weight = CORNER_WEIGHT;
                    acc += win_cols[src][r][ch] * weight;
                end
            end
            acc = acc >> 8;
            chan[ch] = (acc > 255) ? 8'hff : 8'(acc);
        end
        res.red   = chan[rgbgb_pkg::CH_RED];
        res.green = chan[rgbgb_pkg::CH_GREEN];
        res.blue  = chan[rgbgb_pkg::CH_BLUE];
        res.eof   = eof;
        res.last  = 1'b0;
        return res;
    endfunction

    task automatic shift_column(input rgbgb_pkg::pix_t top, input rgbgb_pkg::pix_t mid,
                                input rgbgb_pkg::pix_t bot,
                                input int unsigned c, input int unsigned w,
                                input logic may_emit, input logic is_drain);
        blur_result_t res[2];
        int           n;
        int           k;
        if (c == 0)
        begin
            for (k = 0; k < 3; k++)
            begin
                win_cols[k][0] = top;
                win_cols[k][1] = mid;
                win_cols[k][2] = bot;
            end
        end
        else
        begin
            for (k = 0; k < 3; k++)
            begin
                win_cols[0][k] = win_cols[1][k];
                win_cols[1][k] = win_cols[2][k];
            end
            win_cols[2][0] = top;
            win_cols[2][1] = mid;
            win_cols[2][2] = bot;
        end
        if (!may_emit)
            return;
        n = 0;
        if (c >= 1)
        begin
            res[n] = blur_pixels(1'b0, 1'b0);
            n++;
        end
        if (c + 1 >= w)
        begin
            res[n] = blur_pixels(1'b1, is_drain);
            n++;
        end
        if (n > 0)
            res[n-1].last = 1'b1;
        for (k = 0; k < n; k++)
            expected_q.push_back(res[k]);
    endtask

    task automatic predict_blur(input logic item_op, input rgbgb_pkg::pix_t px);
        int unsigned     w;
        int unsigned     h;
        int unsigned     c;
        int unsigned     idx;
        rgbgb_pkg::pix_t top;
        rgbgb_pkg::pix_t mid;
        w = active_width();
        h = active_height();
        if (item_op == rgbgb_pkg::OP_PIXEL)
        begin
            if (row_cnt >= h)
                return;
            c = col_cnt;
            idx = (c < LINE_DEPTH) ? c : LINE_DEPTH - 1;
            mid = middle_store[idx];
            top = (row_cnt <= 1) ? mid : upper_store[idx];
            upper_store[idx] = mid;
            middle_store[idx] = px;
            shift_column(top, mid, px, c, w, row_cnt >= 1, 1'b0);
            if (c + 1 >= w)
            begin
                col_cnt = 0;
                row_cnt = (row_cnt + 1) & 12'hfff;
            end
            else
                col_cnt = c + 1;
        end
        else
        begin
            if (row_cnt < h)
                return;
            c = drain_cnt;
            idx = (c < LINE_DEPTH) ? c : LINE_DEPTH - 1;
            mid = middle_store[idx];
            top = (h == 1) ? mid : upper_store[idx];
            shift_column(top, mid, mid, c, w, 1'b1, 1'b1);
            if (c + 1 >= w)
            begin
                drain_cnt = 0;
                col_cnt = 0;
                row_cnt = 0;
            end
            else
                drain_cnt = c + 1;
        end
    endtask

    task automatic send_item(input logic item_op, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b);
        int unsigned gap;
        gap = idle_gap(send_idle);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= item_op;
        in_red   <= r;
        in_green <= g;
        in_blue  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_blur(item_op, {r, g, b});
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_frame_size(input logic [rgbgb_pkg::CFG_W-1:0] w,
                                    input logic [rgbgb_pkg::CFG_W-1:0] h);
        cfg_write_en <= 1'b1;
        cfg_index    <= rgbgb_pkg::REG_FRAME_WIDTH;
        cfg_data     <= w;
        @(posedge clk);
        width_reg = w;
        cfg_index <= rgbgb_pkg::REG_FRAME_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        height_reg = h;
        cfg_write_en <= 1'b0;
    endtask

    task automatic send_pixel(input int unsigned n, input logic chequer);
        if (chequer)
            send_item(rgbgb_pkg::OP_PIXEL, (n % 2) ? 8'hff : 8'h00,
                      (n % 3 == 0) ? 8'hff : 8'h00, ((n / 3) % 2) ? 8'h00 : 8'hff);
        else
            send_item(rgbgb_pkg::OP_PIXEL, random_channel(), random_channel(),
                      random_channel());
        counted_items++;
    endtask

    // noise items are ones the block must ignore: drains mid-frame, pixels after the frame
    task automatic stream_frame(input int unsigned cols, input int unsigned rows,
                                input int unsigned noise_pct, input logic chequer);
        int unsigned i;
        for (i = 0; i < cols * rows; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_item(rgbgb_pkg::OP_DRAIN, random_channel(), random_channel(),
                          random_channel());
            send_pixel(i, chequer);
        end
        for (i = 0; i < cols; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_item(rgbgb_pkg::OP_PIXEL, random_channel(), random_channel(),
                          random_channel());
            send_item(rgbgb_pkg::OP_DRAIN, random_channel(), random_channel(),
                      random_channel());
            counted_items++;
        end
    endtask

    task automatic test_extreme_pixels();
        wait_idle();
        write_frame_size(12'd3, 12'd3);
        stream_frame(3, 2, 0, 1'b1);
        // stray drain inside the frame
        send_item(rgbgb_pkg::OP_DRAIN, 8'hff, 8'hff, 8'hff);
        send_pixel(6, 1'b1);
        send_pixel(7, 1'b1);
        send_pixel(8, 1'b1);
        // stray pixel once the frame is complete
        send_item(rgbgb_pkg::OP_PIXEL, 8'hff, 8'h00, 8'hff);
        stream_frame(3, 0, 0, 1'b1);
        wait_idle();
    endtask

    task automatic test_single_column();
        // zero sizes act as one
        write_frame_size(12'd0, 12'd0);
        stream_frame(1, 1, 0, 1'b1);
        wait_idle();
        write_frame_size(12'd1, 12'd2);
        stream_frame(1, 2, 0, 1'b0);
        wait_idle();
    endtask

    task automatic test_size_change_mid_frame();
        int unsigned i;
        write_frame_size(12'd8, 12'd4);
        for (i = 0; i < 5; i++)
            send_pixel(i, 1'b0);
        wait_idle();
        // column counter already past the new last column
        write_frame_size(12'd3, 12'd4);
        for (i = 0; i < 7; i++)
            send_pixel(i, 1'b0);
        wait_idle();
        // frame ends early once the height drops to the current row
        write_frame_size(12'd3, 12'd3);
        stream_frame(3, 0, 0, 1'b0);
        wait_idle();
    endtask

    task automatic test_output_hold();
        write_frame_size(12'd8, 12'd6);
        send_idle = 1'b0;
        hold_requests++;
        stream_frame(8, 6, 0, 1'b0);
        send_idle = 1'b1;
        wait_idle();
    endtask

    task automatic test_random_frames();
        int unsigned start;
        logic        first;
        start = counted_items;
        first = 1'b1;
        while (counted_items - start < RANDOM_ITEMS)
        begin
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            if (first || $urandom_range(0, 1))
            begin
                wait_idle();
                write_frame_size(($urandom_range(0, 9) == 0) ? 12'($urandom_range(1, 64))
                                                             : 12'($urandom_range(1, 8)),
                                 12'($urandom_range(1, 6)));
                first = 1'b0;
            end
            stream_frame(active_width(), active_height(), 8, 1'b0);
        end
        send_idle = 1'b1;
        recv_idle = 1'b1;
        wait_idle();
    endtask

    task automatic test_extreme_sizes();
        int unsigned i;
        // oversized width clamps to the line length, so no row ends here
        write_frame_size(12'd4095, 12'd4095);
        for (i = 0; i < 3; i++)
            send_pixel(i, 1'b0);
        wait_idle();
        // narrower width ends the row at once, single-row frame then drains
        write_frame_size(12'd3, 12'd1);
        send_pixel(3, 1'b0);
        stream_frame(3, 0, 0, 1'b0);
        wait_idle();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extreme_pixels();
        test_single_column();
        test_size_change_mid_frame();
        test_output_hold();
        test_random_frames();
        test_extreme_sizes();
        wait_idle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // output side: random stall per result, plus one long hold on request
    initial
    begin
        int wait_cycles;
        int holds_taken;
        holds_taken = 0;
        forever
        begin
            if (hold_requests != holds_taken)
            begin
                wait_cycles = HOLD_CYCLES;
                holds_taken = hold_requests;
            end
            else
                wait_cycles = int'(idle_gap(recv_idle));
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        blur_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected item, expected none, got rgb %0d %0d %0d",
                         $time, out_red, out_green, out_blue);
            end
            else
            begin
                want = expected_q.pop_front();
                check_field("out_red", want.red, out_red);
                check_field("out_green", want.green, out_green);
                check_field("out_blue", want.blue, out_blue);
                check_field("end_of_frame", 8'(want.eof), 8'(end_of_frame));
                check_field("run_last", 8'(want.last), 8'(run_last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d items still expected", $time, expected_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule

`default_nettype wire

// ===== rgb_gaussian_blur_3x3_core.f =====
+incdir+sv
sv/rgbgb_pkg.sv
sv/rgbgb_queue.sv
sv/rgbgb_front.sv
sv/rgbgb_back.sv
sv/rgb_gaussian_blur_3x3_core.sv
verif/rgb_gaussian_blur_3x3_core_tb.sv
